### hw/rtl/sidau_pkg.sv
// ----------------------------------------------------------------------------
// sidau_pkg
// Shared types and constants for the signed integer to decimal text unit.
// ----------------------------------------------------------------------------
package sidau_pkg;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned DIGITS  = 10;
    localparam int unsigned DIGIT_W = 4;
    localparam int unsigned CHAR_W  = 8;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;

    // per-cycle control broadcast to every digit cell
    typedef struct packed {
        logic clr;     // zero the digit
        logic dabble;  // add-3 adjust and shift one binary bit in
        logic move;    // take the lower neighbor's digit
    } t_cell_ctrl;

endpackage

### hw/rtl/signed_int_to_decimal_ascii_unit.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_unit
// Converts a 32-bit signed integer into its decimal ASCII text.
// ----------------------------------------------------------------------------
// One 32-bit two's complement value is taken per input beat and comes out as
// 1 to 11 ASCII beats, most significant character first, a leading '-' for a
// negative value, no leading zeros, tlast on the final character. The
// magnitude is converted by a chain of ten BCD digit cells that shift in one
// binary bit per cycle, then a negative value's '-' is registered once the
// output register is free, then the chain shifts digits to its top end one
// per cycle: leading zeros are dropped there without waiting on the output,
// and each printed digit moves only when the output register is free. A new
// value is taken once the last character has been placed in the output
// register.
module signed_int_to_decimal_ascii_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] value
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [7:0] character
    output logic        o_m_tlast
);

    localparam int unsigned CNT_W  = $clog2(sidau_pkg::VALUE_W);
    localparam int unsigned LEFT_W = $clog2(sidau_pkg::DIGITS + 1);

    typedef enum logic [1:0] {S_IDLE, S_CONV, S_SIGN, S_EMIT} t_state;

    t_state                             r_state;
    logic                               r_neg;
    logic [sidau_pkg::VALUE_W-1:0]      r_mag;
    logic [CNT_W-1:0]                   r_cnt;
    logic [LEFT_W-1:0]                  r_left;
    logic                               r_started;
    logic                               r_out_valid;
    logic [sidau_pkg::CHAR_W-1:0]       r_out_char;
    logic                               r_out_last;

    sidau_pkg::t_cell_ctrl              w_ctrl;
    logic [sidau_pkg::DIGITS:0]         w_bit;
    logic [sidau_pkg::DIGIT_W-1:0]      w_din [sidau_pkg::DIGITS+1];
    logic [sidau_pkg::DIGIT_W-1:0]      w_top;
    logic                               w_accept;
    logic                               w_out_free;
    logic                               w_skip;
    logic                               w_print;
    logic                               w_load;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_top      = w_din[sidau_pkg::DIGITS];

    // leading zero: drop it, unless it is the units digit
    assign w_skip  = (r_state == S_EMIT) && !r_started && (w_top == '0)
                     && (r_left != LEFT_W'(1));
    assign w_print = (r_state == S_EMIT) && !w_skip && w_out_free;
    assign w_load  = ((r_state == S_SIGN) && w_out_free) || w_print;

    always_comb begin
        w_ctrl.clr    = w_accept;
        w_ctrl.dabble = (r_state == S_CONV);
        w_ctrl.move   = w_skip || w_print;
    end

    assign w_bit[0] = r_mag[sidau_pkg::VALUE_W-1];
    assign w_din[0] = '0;

    for (genvar g = 0; g < sidau_pkg::DIGITS; g++) begin : g_cell
        sidau_bcd_cell u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_bit   (w_bit[g]),
            .i_digit (w_din[g]),
            .o_carry (w_bit[g+1]),
            .o_digit (w_din[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_left      <= '0;
            r_started   <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_neg   <= i_s_tdata[sidau_pkg::VALUE_W-1];
                        r_mag   <= i_s_tdata[sidau_pkg::VALUE_W-1] ? (~i_s_tdata + 32'd1)
                                                                   : i_s_tdata;
                        r_cnt   <= '0;
                        r_state <= S_CONV;
                    end
                end
                S_CONV: begin
                    r_mag <= {r_mag[sidau_pkg::VALUE_W-2:0], 1'b0};
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(sidau_pkg::VALUE_W - 1)) begin
                        r_left    <= LEFT_W'(sidau_pkg::DIGITS);
                        r_started <= 1'b0;
                        r_state   <= r_neg ? S_SIGN : S_EMIT;
                    end
                end
                S_SIGN: begin
                    if (w_out_free) begin
                        r_out_char  <= sidau_pkg::CHAR_MINUS;
                        r_out_last  <= 1'b0;
                        r_state     <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_skip) begin
                        r_left <= r_left - LEFT_W'(1);
                    end else if (w_print) begin
                        r_out_char  <= sidau_pkg::CHAR_ZERO
                                       + {{(sidau_pkg::CHAR_W-sidau_pkg::DIGIT_W){1'b0}}, w_top};
                        r_out_last  <= (r_left == LEFT_W'(1));
                        r_started   <= 1'b1;
                        r_left      <= r_left - LEFT_W'(1);
                        if (r_left == LEFT_W'(1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_char;
    assign o_m_tlast  = r_out_last;

endmodule

### hw/rtl/sidau_bcd_cell.sv
// ----------------------------------------------------------------------------
// sidau_bcd_cell
// One decimal digit of the double-dabble chain; also shifts digits toward
// the top of the chain when the text is read out.
// ----------------------------------------------------------------------------
module sidau_bcd_cell (
    input  logic                                i_clk,
    input  sidau_pkg::t_cell_ctrl               i_ctrl,
    input  logic                                i_bit,
    input  logic [sidau_pkg::DIGIT_W-1:0]       i_digit,
    output logic                                o_carry,
    output logic [sidau_pkg::DIGIT_W-1:0]       o_digit
);

    logic [sidau_pkg::DIGIT_W-1:0] r_digit;
    logic [sidau_pkg::DIGIT_W-1:0] w_adj;

    assign w_adj   = (r_digit >= 4'd5) ? r_digit + 4'd3 : r_digit;
    assign o_carry = w_adj[sidau_pkg::DIGIT_W-1];
    assign o_digit = r_digit;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.clr) begin
            r_digit <= '0;
        end else if (i_ctrl.dabble) begin
            r_digit <= {w_adj[sidau_pkg::DIGIT_W-2:0], i_bit};
        end else if (i_ctrl.move) begin
            r_digit <= i_digit;
        end
    end

endmodule

### verif/signed_int_to_decimal_ascii_unit_tb.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_unit_tb
// Self-checking bench for the signed integer to decimal text unit.
// ----------------------------------------------------------------------------
// Integers go in on the slave stream. A scoreboard works out the text of each
// accepted integer and checks every character beat, and its tlast flag, in
// order. A directed set covers zero, single digits, decade edges and both
// extremes. Random integers follow in three rounds: first the sender idles
// lightly and the receiver heavily, then the reverse, then neither idles.
// The last round also holds the output off for a long stretch.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_unit_tb;

    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;
    localparam int ROUND_ITEMS = 117;

    typedef struct packed {
        logic [sidau_pkg::CHAR_W-1:0] code;
        logic                         last;
    } t_char_beat;

    class decimal_text_board;
        t_char_beat text_q[$];
        int         errors;
        int         reported;

        function new();
            errors   = 0;
            reported = 0;
        endfunction

        function void flag(string what);
            errors++;
            if (reported < 10) begin
                reported++;
                $display("mismatch: %s", what);
            end
        endfunction

        // queue the characters of one accepted integer
        function void note_value(logic [sidau_pkg::VALUE_W-1:0] value);
            logic [sidau_pkg::VALUE_W-1:0] mag;
            logic [sidau_pkg::VALUE_W-1:0] rem;
            logic [sidau_pkg::DIGIT_W-1:0] digs[sidau_pkg::DIGITS];
            int                            nd;
            t_char_beat                    beat;
            mag = value[sidau_pkg::VALUE_W-1] ? (32'd0 - value) : value;
            nd  = 0;
            do begin
                rem      = mag % 32'd10;
                digs[nd] = rem[sidau_pkg::DIGIT_W-1:0];
                nd++;
                mag = mag / 32'd10;
            end while (mag != 32'd0 && nd < sidau_pkg::DIGITS);
            if (value[sidau_pkg::VALUE_W-1]) begin
                beat.code = sidau_pkg::CHAR_MINUS;
                beat.last = 1'b0;
                text_q.push_back(beat);
            end
            for (int k = nd - 1; k >= 0; k--) begin
                beat.code = sidau_pkg::CHAR_ZERO
                            + {{(sidau_pkg::CHAR_W-sidau_pkg::DIGIT_W){1'b0}}, digs[k]};
                beat.last = (k == 0);
                text_q.push_back(beat);
            end
        endfunction

        function void check_char(logic [sidau_pkg::CHAR_W-1:0] code, logic last);
            t_char_beat want;
            if (text_q.size() == 0) begin
                flag($sformatf("unexpected beat '%c' (%h) last %b", code, code, last));
                return;
            end
            want = text_q.pop_front();
            if (code !== want.code || last !== want.last)
                flag($sformatf("expected '%c' (%h) last %b, got '%c' (%h) last %b",
                               want.code, want.code, want.last, code, code, last));
        endfunction

        function int chars_pending();
            return text_q.size();
        endfunction

        function void close_out();
            if (text_q.size() != 0)
                flag($sformatf("%0d characters never arrived", text_q.size()));
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [31:0] i_s_tdata;     // [31:0] value
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [7:0]  o_m_tdata;     // [7:0] character
    logic        o_m_tlast;

    decimal_text_board board = new();

    int send_idle_pct = 15;
    int recv_idle_pct = 55;
    bit hold_req      = 1'b0;

    signed_int_to_decimal_ascii_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic logic [31:0] pow10(int n);
        logic [31:0] p;
        p = 32'd1;
        for (int i = 0; i < n; i++) p = p * 32'd10;
        return p;
    endfunction

    // mix of raw bit patterns, values of a chosen digit count and decade edges
    function automatic logic [31:0] pick_value();
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] v;
        int          kind;
        int          nd;
        kind = $urandom_range(99);
        nd   = $urandom_range(10, 1);
        lo   = (nd == 1) ? 32'd0 : pow10(nd - 1);
        hi   = (nd == 10) ? 32'h7fff_ffff : pow10(nd) - 32'd1;
        if (kind < 35) begin
            v = $urandom;
        end else if (kind < 80) begin
            v = $urandom_range(hi, lo);
        end else begin
            case ($urandom_range(3))
                0: v = lo;
                1: v = hi;
                2: v = lo - 32'd1;
                default: v = 32'h7fff_ffff - 32'($urandom_range(2));
            endcase
        end
        if (kind >= 35 && $urandom_range(1))
            v = 32'd0 - v;
        return v;
    endfunction

    // called just after a rising edge, returns at the edge of acceptance
    task automatic send_value(input logic [31:0] value);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= value;
        do @(posedge i_clk); while (o_s_tready !== 1'b1);
        board.note_value(value);
    endtask

    task automatic run_round(input int n, input int s_pct, input int r_pct, input bit squeeze);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (int i = 0; i < n; i++) begin
            if (squeeze && i == n / 4)
                hold_req = 1'b1;
            send_value(pick_value());
        end
    endtask

    // output side: takes beats, idles at random, long hold on request
    initial begin
        int hold_left;
        hold_left = 0;
        i_m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && i_m_tready && o_m_tvalid === 1'b1)
                board.check_char(o_m_tdata, o_m_tlast);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (i_rst_n !== 1'b1) begin
                i_m_tready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // watchdog on cycles with no beat on either side
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n !== 1'b1 ||
                (i_s_tvalid && o_s_tready === 1'b1) ||
                (i_m_tready && o_m_tvalid === 1'b1))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT) begin
                $display("signed_int_to_decimal_ascii_unit test failed");
                $finish;
            end
        end
    end

    initial begin
        logic [31:0] edge_vals[$];
        edge_vals = '{32'd0, 32'd1, 32'hffff_ffff, 32'd9, 32'hffff_fff7, 32'd10,
                      32'hffff_fff6, 32'd99, 32'd100, 32'd999_999_999,
                      32'd1_000_000_000, 32'hc465_3600, 32'd1_234_567_890,
                      32'hb669_fd2e, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0001,
                      32'h5555_5555, 32'haaaa_aaaa, 32'd2_000_000_000};
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (edge_vals[i])
            send_value(edge_vals[i]);
        run_round(ROUND_ITEMS, 15, 55, 1'b0);
        run_round(ROUND_ITEMS, 55, 15, 1'b0);
        run_round(ROUND_ITEMS, 0, 0, 1'b1);
        i_s_tvalid <= 1'b0;

        while (board.chars_pending() != 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        board.close_out();
        if (board.errors == 0)
            $display("signed_int_to_decimal_ascii_unit test passed");
        else
            $display("signed_int_to_decimal_ascii_unit test failed");
        $finish;
    end

endmodule

### signed_int_to_decimal_ascii_unit.f
hw/rtl/sidau_pkg.sv
hw/rtl/sidau_bcd_cell.sv
hw/rtl/signed_int_to_decimal_ascii_unit.sv
verif/signed_int_to_decimal_ascii_unit_tb.sv
